FILE: rtl/rid_alloc_pkg.sv
// shared constants and types of the recycling identifier allocator
`timescale 1ns / 1ps
package rid_alloc_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int ID_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} rid_state_t;

endpackage

FILE: rtl/recycling_id_allocator.sv
// recycling identifier allocator: free list and in-use memories, request sequencer
`timescale 1ns / 1ps
// On acceptance of a request word the free-list head entry and the in-use bit of
// slot_id are read from their synchronous memories; in the execution state the
// result is decided, the memories are written back and the result word is loaded
// into the output register, after which a new request is taken.
// The output register holds a result while the response side stalls; a request
// is still taken during that time, and it then waits in execution until the
// register can be loaded again. Identifiers at or above the never-used counter
// read as not in use, so neither memory needs a clearing pass after reset and the
// block is ready in the first cycle.
module recycling_id_allocator
	import rid_alloc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            mode,
	input  logic [ID_W-1:0] slot_id,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic [ID_W-1:0] granted_id,
	output logic            success
);

	logic            in_use_mem [MAX_SLOTS];
	logic [ID_W-1:0] queue_mem  [MAX_SLOTS];

	rid_state_t      state_q, state_d;
	logic [ID_W-1:0] queue_head_q, queue_tail_q;
	logic [CNT_W-1:0] queue_count_q, next_fresh_q;
	logic            rsp_valid_q;
	logic [ID_W-1:0] granted_id_q;
	logic            success_q;

	logic            mode_s1;
	logic [ID_W-1:0] slot_id_s1;
	logic [ID_W-1:0] q_rd_s1;
	logic            use_rd_s1;

	logic            req_fire, commit;
	logic            use_we, use_wdata;
	logic [ID_W-1:0] use_waddr;
	logic            q_we;
	logic            pop, take_fresh;
	logic [ID_W-1:0] grant_d;
	logic            ok_d;

	function automatic logic [ID_W-1:0] advance_pos(input logic [ID_W-1:0] pos);
		if (pos == ID_W'(MAX_SLOTS - 1)) begin
			return '0;
		end
		return pos + ID_W'(1);
	endfunction

	assign req_fire  = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		commit     = 1'b0;
		pop        = 1'b0;
		take_fresh = 1'b0;
		grant_d    = '0;
		ok_d       = 1'b0;
		use_we     = 1'b0;
		use_wdata  = 1'b0;
		use_waddr  = slot_id_s1;
		q_we       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!(rsp_valid_q && rsp_stall)) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
					if (mode_s1 == MODE_ALLOC) begin
						if (queue_count_q != '0) begin
							pop     = 1'b1;
							grant_d = q_rd_s1;
							ok_d    = 1'b1;
						end else if (next_fresh_q < CNT_W'(MAX_SLOTS)) begin
							take_fresh = 1'b1;
							grant_d    = next_fresh_q[ID_W-1:0];
							ok_d       = 1'b1;
						end
						use_we    = ok_d;
						use_wdata = 1'b1;
						use_waddr = grant_d;
					end else begin
						ok_d = (slot_id_s1 != '0) && ({1'b0, slot_id_s1} < next_fresh_q) &&
							use_rd_s1 && (queue_count_q < CNT_W'(MAX_SLOTS));
						use_we    = ok_d;
						use_wdata = 1'b0;
						use_waddr = slot_id_s1;
						q_we      = ok_d;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (use_we) begin
			in_use_mem[use_waddr] <= use_wdata;
		end
		if (req_fire) begin
			use_rd_s1 <= in_use_mem[slot_id];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[queue_tail_q] <= slot_id_s1;
		end
		if (req_fire) begin
			q_rd_s1 <= queue_mem[queue_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_s1    <= mode;
			slot_id_s1 <= slot_id;
		end
		if (commit) begin
			granted_id_q <= grant_d;
			success_q    <= ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_head_q  <= '0;
			queue_tail_q  <= '0;
			queue_count_q <= '0;
			next_fresh_q  <= CNT_W'(1);
			rsp_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				queue_head_q  <= advance_pos(queue_head_q);
				queue_count_q <= queue_count_q - CNT_W'(1);
			end
			if (q_we) begin
				queue_tail_q  <= advance_pos(queue_tail_q);
				queue_count_q <= queue_count_q + CNT_W'(1);
			end
			if (take_fresh) begin
				next_fresh_q <= next_fresh_q + CNT_W'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign granted_id = granted_id_q;
	assign success    = success_q;

	// a nonzero granted identifier always comes with success
	a_grant_code: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (granted_id != '0)) |-> success)
		else $error("granted identifier does not match success");

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(queue_count_q <= CNT_W'(MAX_SLOTS)) && (next_fresh_q <= CNT_W'(MAX_SLOTS))
		&& (next_fresh_q != '0))
		else $error("queue count or fresh counter out of range");

	// free-list pointers agree with the queue count while the list is not full
	a_queue_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(queue_count_q < CNT_W'(MAX_SLOTS)) |->
		((queue_tail_q - queue_head_q) == queue_count_q[ID_W-1:0]))
		else $error("free list pointers disagree with count");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !(rsp_valid_q && rsp_stall)) |=>
		(rsp_valid && state_q == ST_IDLE))
		else $error("executed request produced no result word");

endmodule
